### rtl/pbhp_pkg.sv
// Shared constants and codes for the power button hold policy block.
package pbhp_pkg;

    localparam int TIME_BITS     = 48;
    localparam int IDLE_BITS     = 48;
    localparam int HOLD_BITS     = 32;
    localparam int MV_BITS       = 16;
    localparam int SEC_BITS      = 16;
    localparam int ACT_BITS      = 3;
    localparam int PROG_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // microseconds per second, used to scale the idle limit
    localparam int US_PER_S_BITS = 20;
    localparam logic [US_PER_S_BITS-1:0] US_PER_S = 20'd1000000;
    localparam int IDLE_LIM_BITS = SEC_BITS + US_PER_S_BITS;

    // long division: one quotient bit per step
    localparam int DIV_STEPS    = PROG_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam int NUM_BITS     = HOLD_BITS + PROG_BITS;
    localparam int DEN_BITS     = HOLD_BITS + PROG_BITS - 1;

    localparam logic [PROG_BITS-1:0] PROG_FULL = '1;

    // config register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_TIME = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BATT_CUTOFF  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_OFF     = 2'd3;

    localparam logic [HOLD_BITS-1:0] HOLD_TIME_RST    = 32'd3000000;
    localparam logic [HOLD_BITS-1:0] CONFIRM_TIME_RST = 32'd6000000;

    // power actions
    localparam logic [ACT_BITS-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_WAKE    = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_HOLD    = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_TIMER   = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_RELEASE = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_USB     = 3'd5;
    localparam logic [ACT_BITS-1:0] ACT_OFF     = 3'd6;

endpackage

### rtl/power_button_hold_policy.sv
// Power button hold policy: per-frame power action and hold progress.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | in        | in_valid / in_stall   | button_down, now_us, blanked, timer_running,
//          |           |                       | on_usb, alarm_sounding, battery_valid,
//          |           |                       | battery_mv, idle_us
//  out     | out       | out_valid / out_stall | action, progress
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A word passes through the captured-word registers and the result registers to the output
// register, with the divider steps between when a hold progress value is needed: the 8-bit
// quotient comes out of one 40-bit compare/subtract unit, one bit per cycle. in_stall is high
// while a word is in work, so a new word is taken only after the last result is loaded.
// A finished result waits in a holding state while the output register is stalled.
// rst_n clears the policy state and loads the register defaults; cfg_ready is always high.
module power_button_hold_policy
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              button_down,
    input  logic [pbhp_pkg::TIME_BITS-1:0]    now_us,
    input  logic                              blanked,
    input  logic                              timer_running,
    input  logic                              on_usb,
    input  logic                              alarm_sounding,
    input  logic                              battery_valid,
    input  logic [pbhp_pkg::MV_BITS-1:0]      battery_mv,
    input  logic [pbhp_pkg::IDLE_BITS-1:0]    idle_us,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pbhp_pkg::ACT_BITS-1:0]     action,
    output logic [pbhp_pkg::PROG_BITS-1:0]    progress,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbhp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [pbhp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import pbhp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // config
    logic [HOLD_BITS-1:0]  hold_time_reg,    hold_time_next;
    logic [HOLD_BITS-1:0]  confirm_time_reg, confirm_time_next;
    logic [MV_BITS-1:0]    batt_cutoff_reg,  batt_cutoff_next;
    logic [SEC_BITS-1:0]   idle_off_reg,     idle_off_next;

    // policy state
    logic                  seen_release_reg, seen_release_next;
    logic                  was_pressed_reg,  was_pressed_next;
    logic [TIME_BITS-1:0]  press_start_reg,  press_start_next;
    logic                  armed_reg,        armed_next;

    // sequencer and captured word
    logic [1:0]            state_reg,   state_next;
    logic                  down_reg,    down_next;
    logic [TIME_BITS-1:0]  now_reg,     now_next;
    logic [TIME_BITS-1:0]  held_reg,    held_next;
    logic                  blanked_reg, blanked_next;
    logic                  timer_reg,   timer_next;
    logic                  usb_reg,     usb_next;
    logic                  alarm_reg,   alarm_next;
    logic                  bvalid_reg,  bvalid_next;
    logic [MV_BITS-1:0]    mv_reg,      mv_next;
    logic [IDLE_BITS-1:0]  idle_reg,    idle_next;
    logic [IDLE_LIM_BITS-1:0] idle_lim_reg, idle_lim_next;

    // divider
    logic [NUM_BITS-1:0]     num_reg, num_next;
    logic [DEN_BITS-1:0]     den_reg, den_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;

    // result
    logic [ACT_BITS-1:0]   res_act_reg,  res_act_next;
    logic [PROG_BITS-1:0]  res_prog_reg, res_prog_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ACT_BITS-1:0]   out_act_reg,  out_act_next;
    logic [PROG_BITS-1:0]  out_prog_reg, out_prog_next;

    logic in_take;
    logic out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign action    = out_act_reg;
    assign progress  = out_prog_reg;

    always_comb
    begin
        logic                 sr;
        logic [HOLD_BITS-1:0] target;
        logic                 ge_target;
        logic                 ge_hold;
        logic                 batt_low;
        logic                 idle_hit;
        logic                 div_ge;

        hold_time_next    = hold_time_reg;
        confirm_time_next = confirm_time_reg;
        batt_cutoff_next  = batt_cutoff_reg;
        idle_off_next     = idle_off_reg;
        seen_release_next = seen_release_reg;
        was_pressed_next  = was_pressed_reg;
        press_start_next  = press_start_reg;
        armed_next        = armed_reg;
        state_next        = state_reg;
        down_next         = down_reg;
        now_next          = now_reg;
        held_next         = held_reg;
        blanked_next      = blanked_reg;
        timer_next        = timer_reg;
        usb_next          = usb_reg;
        alarm_next        = alarm_reg;
        bvalid_next       = bvalid_reg;
        mv_next           = mv_reg;
        idle_next         = idle_reg;
        idle_lim_next     = idle_lim_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        cnt_next          = cnt_reg;
        res_act_next      = res_act_reg;
        res_prog_next     = res_prog_reg;
        out_valid_next    = out_valid_reg;
        out_act_next      = out_act_reg;
        out_prog_next     = out_prog_reg;

        sr        = seen_release_reg | ~down_reg;
        target    = timer_reg ? confirm_time_reg : hold_time_reg;
        ge_target = (held_reg >= TIME_BITS'(target));
        ge_hold   = (held_reg >= TIME_BITS'(hold_time_reg));
        batt_low  = bvalid_reg && (batt_cutoff_reg != '0) && (mv_reg < batt_cutoff_reg);
        idle_hit  = (idle_off_reg != '0) && (idle_reg >= IDLE_BITS'(idle_lim_reg));
        div_ge    = (num_reg >= NUM_BITS'(den_reg));

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HOLD_TIME:    hold_time_next    = cfg_data[HOLD_BITS-1:0];
                REG_CONFIRM_TIME: confirm_time_next = cfg_data[HOLD_BITS-1:0];
                REG_BATT_CUTOFF:  batt_cutoff_next  = cfg_data[MV_BITS-1:0];
                REG_IDLE_OFF:     idle_off_next     = cfg_data[SEC_BITS-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    down_next     = button_down;
                    now_next      = now_us;
                    held_next     = now_us - press_start_reg;
                    blanked_next  = blanked;
                    timer_next    = timer_running;
                    usb_next      = on_usb;
                    alarm_next    = alarm_sounding;
                    bvalid_next   = battery_valid;
                    mv_next       = battery_mv;
                    idle_next     = idle_us;
                    idle_lim_next = IDLE_LIM_BITS'(idle_off_reg) * IDLE_LIM_BITS'(US_PER_S);
                    state_next    = ST_CALC;
                end
            end
            ST_CALC:
            begin
                seen_release_next = sr;
                was_pressed_next  = down_reg;
                res_act_next      = ACT_NONE;
                res_prog_next     = '0;
                state_next        = ST_DONE;
                if (down_reg && !sr)
                begin
                    // press already down before the first release: ignore
                end
                else if (down_reg)
                begin
                    if (!was_pressed_reg)
                    begin
                        press_start_next = now_reg;
                        armed_next       = 1'b0;
                        res_act_next     = blanked_reg ? ACT_WAKE : ACT_NONE;
                    end
                    else if (ge_target)
                    begin
                        armed_next    = 1'b1;
                        res_act_next  = usb_reg ? ACT_USB : ACT_RELEASE;
                        res_prog_next = PROG_FULL;
                    end
                    else
                    begin
                        // held < target < 2^32, so held*255/target fits in 8 bits
                        res_act_next = (timer_reg && ge_hold) ? ACT_TIMER : ACT_HOLD;
                        num_next     = {held_reg[HOLD_BITS-1:0], {PROG_BITS{1'b0}}}
                                       - NUM_BITS'(held_reg[HOLD_BITS-1:0]);
                        den_next     = {target, {(PROG_BITS-1){1'b0}}};
                        cnt_next     = '0;
                        state_next   = ST_DIV;
                    end
                end
                else if (was_pressed_reg)
                begin
                    armed_next = 1'b0;
                    if (armed_reg)
                    begin
                        res_act_next = usb_reg ? ACT_USB : ACT_OFF;
                    end
                end
                else if (!timer_reg && !alarm_reg && (batt_low || idle_hit))
                begin
                    res_act_next = usb_reg ? ACT_NONE : ACT_OFF;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    num_next = num_reg - NUM_BITS'(den_reg);
                end
                res_prog_next = {res_prog_reg[PROG_BITS-2:0], div_ge};
                den_next      = den_reg >> 1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = res_act_reg;
                    out_prog_next  = res_prog_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg    <= HOLD_TIME_RST;
            confirm_time_reg <= CONFIRM_TIME_RST;
            batt_cutoff_reg  <= '0;
            idle_off_reg     <= '0;
            seen_release_reg <= 1'b0;
            was_pressed_reg  <= 1'b0;
            press_start_reg  <= '0;
            armed_reg        <= 1'b0;
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            hold_time_reg    <= hold_time_next;
            confirm_time_reg <= confirm_time_next;
            batt_cutoff_reg  <= batt_cutoff_next;
            idle_off_reg     <= idle_off_next;
            seen_release_reg <= seen_release_next;
            was_pressed_reg  <= was_pressed_next;
            press_start_reg  <= press_start_next;
            armed_reg        <= armed_next;
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        down_reg     <= down_next;
        now_reg      <= now_next;
        held_reg     <= held_next;
        blanked_reg  <= blanked_next;
        timer_reg    <= timer_next;
        usb_reg      <= usb_next;
        alarm_reg    <= alarm_next;
        bvalid_reg   <= bvalid_next;
        mv_reg       <= mv_next;
        idle_reg     <= idle_next;
        idle_lim_reg <= idle_lim_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        res_act_reg  <= res_act_next;
        res_prog_reg <= res_prog_next;
        out_act_reg  <= out_act_next;
        out_prog_reg <= out_prog_next;
    end

    // armed only while the press that armed it is still down
    a_armed_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> was_pressed_reg)
        else $error("armed without a held press");

    a_take_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_CALC))
        else $error("accepted word did not start evaluation");

    a_prog_action: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_prog_reg != '0)) |->
        ((out_act_reg == ACT_HOLD) || (out_act_reg == ACT_TIMER) ||
         (out_act_reg == ACT_RELEASE) || (out_act_reg == ACT_USB)))
        else $error("progress on an action without hold prompt");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished result not loaded into output register");

endmodule

### sim/tb_power_button_hold_policy.sv
// Self-checking testbench for power_button_hold_policy: directed and random frames vs predictor.
module tb_power_button_hold_policy;
    timeunit 1ns;
    timeprecision 1ps;

    import pbhp_pkg::*;

    typedef struct {
        logic                 button_down;
        logic [TIME_BITS-1:0] now_us;
        logic                 blanked;
        logic                 timer_running;
        logic                 on_usb;
        logic                 alarm_sounding;
        logic                 battery_valid;
        logic [MV_BITS-1:0]   battery_mv;
        logic [IDLE_BITS-1:0] idle_us;
    } frame_t;

    typedef struct {
        logic [ACT_BITS-1:0]  action;
        logic [PROG_BITS-1:0] progress;
    } power_action_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      button_down = 1'b0;
    logic [TIME_BITS-1:0]      now_us = '0;
    logic                      blanked = 1'b0;
    logic                      timer_running = 1'b0;
    logic                      on_usb = 1'b0;
    logic                      alarm_sounding = 1'b0;
    logic                      battery_valid = 1'b0;
    logic [MV_BITS-1:0]        battery_mv = '0;
    logic [IDLE_BITS-1:0]      idle_us = '0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [ACT_BITS-1:0]       action;
    logic [PROG_BITS-1:0]      progress;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // predictor state and limits
    logic                      released_once;
    logic                      down_last;
    logic [TIME_BITS-1:0]      press_t0;
    logic                      off_armed;
    logic [HOLD_BITS-1:0]      lim_hold_us;
    logic [HOLD_BITS-1:0]      lim_confirm_us;
    logic [MV_BITS-1:0]        lim_batt_mv;
    logic [SEC_BITS-1:0]       lim_idle_s;

    power_action_t             expected_actions[$];
    int                        fail_count = 0;
    int                        words_sent = 0;
    logic [TIME_BITS-1:0]      clock_us = '0;
    logic                      send_gaps = 1'b1;
    logic                      stall_bursts = 1'b1;
    int                        stall_run = 0;

    power_button_hold_policy dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_down    (button_down),
        .now_us         (now_us),
        .blanked        (blanked),
        .timer_running  (timer_running),
        .on_usb         (on_usb),
        .alarm_sounding (alarm_sounding),
        .battery_valid  (battery_valid),
        .battery_mv     (battery_mv),
        .idle_us        (idle_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .progress       (progress),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic power_action_t next_action(input frame_t f);
        power_action_t        r;
        logic                 prev;
        logic [TIME_BITS-1:0] held;
        logic [HOLD_BITS-1:0] target;
        logic [63:0]          idle_lim;
        r.action   = ACT_NONE;
        r.progress = '0;
        if (!f.button_down)
            released_once = 1'b1;
        prev      = down_last;
        down_last = f.button_down;
        // press held since power-up is ignored
        if (f.button_down && !released_once)
            return r;
        if (f.button_down)
        begin
            if (!prev)
            begin
                press_t0  = f.now_us;
                off_armed = 1'b0;
                r.action  = f.blanked ? ACT_WAKE : ACT_NONE;
                return r;
            end
            held   = f.now_us - press_t0;
            target = f.timer_running ? lim_confirm_us : lim_hold_us;
            if (held >= TIME_BITS'(target))
            begin
                off_armed  = 1'b1;
                r.action   = f.on_usb ? ACT_USB : ACT_RELEASE;
                r.progress = PROG_FULL;
                return r;
            end
            // held < target < 2^32 here, product fits easily
            r.progress = PROG_BITS'((64'(held) * 64'd255) / 64'(target));
            r.action   = (f.timer_running && held >= TIME_BITS'(lim_hold_us)) ? ACT_TIMER
                                                                             : ACT_HOLD;
            return r;
        end
        if (prev)
        begin
            if (off_armed)
                r.action = f.on_usb ? ACT_USB : ACT_OFF;
            off_armed = 1'b0;
            return r;
        end
        if (!f.timer_running && !f.alarm_sounding)
        begin
            idle_lim = 64'(lim_idle_s) * 64'd1000000;
            if ((f.battery_valid && lim_batt_mv != '0 && f.battery_mv < lim_batt_mv) ||
                (lim_idle_s != '0 && 64'(f.idle_us) >= idle_lim))
                r.action = f.on_usb ? ACT_NONE : ACT_OFF;
        end
        return r;
    endfunction

    function automatic frame_t make_frame(input logic down, input logic [TIME_BITS-1:0] t,
                                          input logic blank, input logic timer,
                                          input logic usb, input logic alarm,
                                          input logic bvalid, input logic [MV_BITS-1:0] mv,
                                          input logic [IDLE_BITS-1:0] idle);
        frame_t f;
        f.button_down    = down;
        f.now_us         = t;
        f.blanked        = blank;
        f.timer_running  = timer;
        f.on_usb         = usb;
        f.alarm_sounding = alarm;
        f.battery_valid  = bvalid;
        f.battery_mv     = mv;
        f.idle_us        = idle;
        return f;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // release frame with battery and idle readings, each clustered around its limit half the time
    function automatic frame_t released_frame();
        logic [MV_BITS-1:0]   mv;
        logic [IDLE_BITS-1:0] idle;
        if ($urandom_range(0, 1) == 1)
            mv = MV_BITS'(32'(lim_batt_mv) + $urandom_range(0, 4) - 2);
        else
            mv = MV_BITS'($urandom());
        if ($urandom_range(0, 1) == 1)
            idle = IDLE_BITS'(64'(lim_idle_s) * 64'd1000000 + 64'($urandom_range(0, 6)) - 64'd3);
        else
            idle = rand48();
        return make_frame(1'b0, clock_us, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0,
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                          1'($urandom_range(0, 1)), mv, idle);
    endfunction

    task automatic send_word(input frame_t f);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        button_down    <= f.button_down;
        now_us         <= f.now_us;
        blanked        <= f.blanked;
        timer_running  <= f.timer_running;
        on_usb         <= f.on_usb;
        alarm_sounding <= f.alarm_sounding;
        battery_valid  <= f.battery_valid;
        battery_mv     <= f.battery_mv;
        idle_us        <= f.idle_us;
        do
            @(posedge clk);
        while (in_stall);
        expected_actions.push_back(next_action(f));
        words_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_HOLD_TIME:    lim_hold_us    = data;
            REG_CONFIRM_TIME: lim_confirm_us = data;
            REG_BATT_CUTOFF:  lim_batt_mv    = data[MV_BITS-1:0];
            REG_IDLE_OFF:     lim_idle_s     = data[SEC_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [31:0] hold, input logic [31:0] confirm,
                              input logic [31:0] batt, input logic [31:0] idle_s);
        wait_idle();
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_CONFIRM_TIME, confirm);
        write_reg(REG_BATT_CUTOFF, batt);
        write_reg(REG_IDLE_OFF, idle_s);
        cfg_valid <= 1'b0;
    endtask

    // one press cycle: a few release frames, press, hold frames, release; else one random frame
    task automatic play_session();
        int unsigned          span;
        logic [TIME_BITS-1:0] t0;
        if ($urandom_range(0, 7) == 0)
        begin
            send_word(make_frame(1'($urandom_range(0, 1)), rand48(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 MV_BITS'($urandom()), rand48()));
            return;
        end
        span = ((lim_hold_us > lim_confirm_us) ? lim_hold_us : lim_confirm_us) / 3 + 2;
        if ($urandom_range(0, 7) == 0)
            clock_us = '1 - TIME_BITS'($urandom_range(0, 3000000));
        repeat ($urandom_range(0, 3))
        begin
            clock_us += TIME_BITS'($urandom_range(0, 1000000));
            send_word(released_frame());
        end
        clock_us += TIME_BITS'($urandom_range(1, 1000));
        t0 = clock_us;
        send_word(make_frame(1'b1, clock_us, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), MV_BITS'($urandom()), rand48()));
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 5))
                0:       clock_us = t0 + TIME_BITS'(lim_hold_us) - $urandom_range(0, 1);
                1:       clock_us = t0 + TIME_BITS'(lim_confirm_us) - $urandom_range(0, 1);
                default: clock_us += TIME_BITS'($urandom_range(0, span));
            endcase
            send_word(make_frame(1'b1, clock_us, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), MV_BITS'($urandom()), rand48()));
        end
        clock_us += TIME_BITS'($urandom_range(0, 100000));
        send_word(released_frame());
    endtask

    task automatic run_phase(input logic [31:0] hold, input logic [31:0] confirm,
                             input logic [31:0] batt, input logic [31:0] idle_s,
                             input int n, input logic bursts);
        int stop_at;
        set_limits(hold, confirm, batt, idle_s);
        send_gaps    = bursts;
        stall_bursts = bursts;
        stop_at      = words_sent + n;
        while (words_sent < stop_at)
            play_session();
    endtask

    task automatic test_startup_press();
        send_word(make_frame(1, '0, 1, 0, 0, 0, 0, '0, '0));
        send_word(make_frame(1, '1, 1, 1, 1, 1, 1, '1, '1));
    endtask

    task automatic test_hold_and_release();
        send_word(make_frame(0, 100, 0, 0, 0, 0, 1, '0, '1));
        send_word(make_frame(1, 1000, 1, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 1501000, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 3001000, 0, 1, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 3001000, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(0, 3100000, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 5000000, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 11000000, 0, 1, 1, 0, 0, 0, 0));
        send_word(make_frame(0, 11100000, 0, 0, 1, 0, 0, 0, 0));
        send_word(make_frame(1, 12000000, 1, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(0, 12500000, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_time_wrap();
        send_word(make_frame(1, 48'hFFFF_FFFF_FC18, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 2999000, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(0, 3000000, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_auto_off();
        // upper bits of the 16-bit limits must be dropped
        set_limits(HOLD_TIME_RST, CONFIRM_TIME_RST, 32'hABCD_0CE4, 32'h1234_0005);
        send_word(make_frame(0, 4000000, 0, 0, 0, 0, 1, 3299, 0));
        send_word(make_frame(0, 4000100, 0, 0, 1, 0, 1, 3299, 0));
        send_word(make_frame(0, 4000200, 0, 1, 0, 0, 1, 3299, 0));
        send_word(make_frame(0, 4000300, 0, 0, 0, 0, 0, 0, 4999999));
        send_word(make_frame(0, 4000400, 0, 0, 0, 0, 0, 0, 5000000));
        send_word(make_frame(0, 4000500, 0, 0, 0, 1, 0, 0, 5000000));
        send_word(make_frame(0, 4000600, 0, 0, 0, 0, 1, 3300, 0));
    endtask

    task automatic test_zero_target();
        set_limits('0, '0, '0, '0);
        send_word(make_frame(1, 50, 1, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 50, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_frame(1, 50, 0, 1, 0, 0, 0, 0, 0));
        send_word(make_frame(0, 60, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_default_limits();
        run_phase(HOLD_TIME_RST, CONFIRM_TIME_RST, 32'h0000_0F00, 32'd3, 180, 1'b1);
    endtask

    task automatic test_short_limits();
        run_phase(32'd1000, 32'd2500, 32'd3300, 32'd1, 180, 1'b1);
    endtask

    task automatic test_min_limits();
        run_phase(32'd1, 32'd1, 32'd1, 32'd0, 120, 1'b1);
    endtask

    task automatic test_max_limits();
        run_phase('1, '1, '1, '1, 150, 1'b1);
    endtask

    task automatic test_confirm_below_hold();
        run_phase(32'd50000, 32'd20000, 32'd4000, 32'd2, 150, 1'b1);
    endtask

    task automatic test_zero_hold();
        run_phase(32'd0, 32'd7, 32'd0, 32'd0, 100, 1'b1);
    endtask

    task automatic test_random_limits();
        run_phase($urandom_range(1, 200000), $urandom_range(1, 400000), $urandom(),
                  {16'($urandom()), 16'($urandom_range(0, 20))}, 120, 1'b1);
    endtask

    task automatic test_back_to_back();
        run_phase(32'd20000, 32'd45000, 32'd3000, 32'd2, 100, 1'b0);
    endtask

    // receiver stalls in bursts, with quiet runs between them
    always @(posedge clk)
    begin
        if (!stall_bursts)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run > 0)
            stall_run--;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_stall <= 1'b1;
            stall_run = $urandom_range(1, 15) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_run = $urandom_range(0, 20);
        end
    end

    always @(posedge clk)
    begin : check_results
        power_action_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_actions.size() == 0)
            begin
                $error("unexpected word: action %0d progress %0d", action, progress);
                fail_count++;
            end
            else
            begin
                want = expected_actions.pop_front();
                if (action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    fail_count++;
                end
                if (progress !== want.progress)
                begin
                    $error("progress: expected %0d, got %0d", want.progress, progress);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        released_once  = 1'b0;
        down_last      = 1'b0;
        press_t0       = '0;
        off_armed      = 1'b0;
        lim_hold_us    = HOLD_TIME_RST;
        lim_confirm_us = CONFIRM_TIME_RST;
        lim_batt_mv    = '0;
        lim_idle_s     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_press();
        test_hold_and_release();
        test_time_wrap();
        test_auto_off();
        test_zero_target();
        test_default_limits();
        test_short_limits();
        test_min_limits();
        test_max_limits();
        test_confirm_below_hold();
        test_zero_hold();
        test_random_limits();
        test_back_to_back();

        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("status: fail");
        $finish;
    end

endmodule
